FILE: rtl/core/bmwf_pkg.sv
// Package for the binary morphology window filter.
// Holds register codes, field widths, payload structs and the geometry record.
// No dependencies; compile first.
package bmwf_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned KmaxDef      = 5;
  localparam int unsigned MaskStride   = 5;

  localparam int unsigned DimW     = 11;
  localparam int unsigned KW       = 3;
  localparam int unsigned MaskW    = 25;
  localparam int unsigned LagW     = 14;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 25;

  localparam logic [DimW-1:0]  RstImgDim = 11'd512;
  localparam logic [KW-1:0]    RstKDim   = 3'd5;
  localparam logic [KW-1:0]    RstAnchor = 3'd2;
  localparam logic [MaskW-1:0] RstMask   = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE,
    CFG_IMG_WIDTH,
    CFG_IMG_HEIGHT,
    CFG_KERNEL_ROWS,
    CFG_KERNEL_COLS,
    CFG_ANCHOR_ROW,
    CFG_ANCHOR_COL,
    CFG_KERNEL_MASK
  } cfg_reg_e;

  typedef struct packed {
    logic req_type;
    logic pixel_in;
  } in_item_t;

  typedef struct packed {
    logic pixel_out;
    logic last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic             erode;
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
    logic [KW-1:0]    dr;
    logic [KW-1:0]    dc;
    logic [MaskW-1:0] mask;
  } geom_t;

  typedef struct packed {
    logic            step;
    logic            emit;
    logic            last;
    logic            pixel;
    logic [DimW-1:0] row;
    logic [DimW-1:0] col;
  } step_t;

endpackage

FILE: rtl/core/bmwf_stream_if.sv
// Valid/ready channel with a typed payload.
// Used for the pixel input, the pixel output and the register write port.
// Payload types come from bmwf_pkg at the instantiation.
interface bmwf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/binary_morphology_window_filter.sv
// Binary dilation/erosion over a window of up to 5x5 on a raster pixel stream.
// One pixel or flush transaction is taken per cycle unless the input stalls or
// the window steps alone; the filtered pixel for a step is registered in the
// stage-1 registers and then held in an output register; while it waits, one
// more result moves into that staging register and then the input stalls.
// Output position p trails the input by the element's reach below and right of
// the origin (rows times image width plus columns), so that many flush
// transactions follow each frame; when that reach exceeds the frame's pixel
// count, the block first steps the window alone for the difference before
// taking the first flush. The row memory holds (KDIM - 1) bits per image column,
// one less than the largest window side; its contents are not cleared after reset.
module binary_morphology_window_filter
  import bmwf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef,
  parameter int unsigned KMAX       = KmaxDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bmwf_stream_if.sink   cfg_i,
  bmwf_stream_if.sink   pix_i,
  bmwf_stream_if.source pix_o
);

  localparam int unsigned KDIM = (KMAX < MaskStride) ? KMAX : MaskStride;
  localparam int unsigned TW   = DimW + 2;

  geom_t           geom;
  step_t           step;
  logic            pad;
  logic            stall;
  logic            s1_adv;
  logic            s1_emit_q;
  logic            s1_last_q;
  logic [DimW-1:0] s1_row_q;
  logic [DimW-1:0] s1_col_q;
  logic            out_valid_q;
  out_item_t       out_item_q;

  logic [KDIM-1:0] lb_col;
  logic [KDIM-1:0] win_col [KDIM];
  logic [KDIM-1:0] cell_mask [KDIM];
  logic [KDIM-1:0] row_ok;
  logic [KDIM-1:0] col_ok;
  logic [KDIM-1:0] hit;
  logic [TW-1:0]   t_row;
  logic [TW-1:0]   t_col;
  logic            any_hit;

  bmwf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .KDIM      (KDIM)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .pix_i  (pix_i),
    .stall_i(stall),
    .geom_o (geom),
    .step_o (step),
    .pad_o  (pad)
  );

  bmwf_line_buf #(
    .MAX_WIDTH(MAX_WIDTH),
    .KDIM     (KDIM)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (geom.width),
    .step_i   (step.step),
    .restart_i(step.emit && step.last),
    .pixel_i  (step.pixel),
    .col_o    (lb_col)
  );

  assign t_row = TW'(s1_row_q) + TW'(geom.dr);
  assign t_col = TW'(s1_col_q) + TW'(geom.dc);

  always_comb begin
    for (int a = 0; a < KDIM; a++) begin
      row_ok[a] = (t_row >= TW'(a)) && ((t_row - TW'(a)) < TW'(geom.height));
      col_ok[a] = (t_col >= TW'(a)) && ((t_col - TW'(a)) < TW'(geom.width));
      for (int b = 0; b < KDIM; b++) begin
        cell_mask[a][b] = geom.mask[b*MaskStride+a];
      end
    end
  end

  for (genvar b = 0; b < KDIM; b++) begin : g_cell
    bmwf_cell #(
      .KDIM(KDIM)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step.step),
      .col_i   ((b == 0) ? lb_col : win_col[(b == 0) ? 0 : b-1]),
      .col_o   (win_col[b]),
      .erode_i (geom.erode),
      .col_ok_i(col_ok[b]),
      .row_ok_i(row_ok),
      .mask_i  (cell_mask[b]),
      .hit_o   (hit[b])
    );
  end

  assign any_hit = |hit;
  assign stall   = s1_emit_q && out_valid_q && !pix_o.ready;
  assign s1_adv  = s1_emit_q && !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_emit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step.step) begin
        s1_emit_q <= step.emit;
      end else if (s1_adv) begin
        s1_emit_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.step) begin
      s1_row_q  <= step.row;
      s1_col_q  <= step.col;
      s1_last_q <= step.last;
    end
    if (s1_adv) begin
      out_item_q.pixel_out     <= geom.erode ? !any_hit : any_hit;
      out_item_q.last_of_frame <= s1_last_q;
    end
  end

  assign pix_o.valid   = out_valid_q;
  assign pix_o.payload = out_item_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) stall |-> !step.step)
    else $error("window stepped while a result was held");

  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_q) |-> $past(s1_emit_q))
    else $error("output raised without a pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pad |-> !pix_i.ready)
    else $error("input taken while the window advances alone");

  assert property (@(posedge clk_i) disable iff (!rst_ni) step.emit |-> step.step)
    else $error("result emitted without a stream step");

endmodule

FILE: rtl/core/bmwf_line_buf.sv
// Row delay memory of the filter: one word per column holds the older rows.
// Read data is prefetched and registered, with a bypass for single-column images.
// Depends on bmwf_pkg.
module bmwf_line_buf
  import bmwf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDef,
  parameter int unsigned KDIM      = KmaxDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DimW-1:0]  width_i,
  input  logic             step_i,
  input  logic             restart_i,
  input  logic             pixel_i,
  output logic [KDIM-1:0]  col_o
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);
  localparam int unsigned WordW = KDIM - 1;
  localparam int unsigned CmpW  = ((AddrW > DimW) ? AddrW : DimW) + 1;

  logic [WordW-1:0] mem_q [MAX_WIDTH];
  logic [WordW-1:0] rdata_q;
  logic [WordW-1:0] fwd_word_q;
  logic             fwd_q;
  logic [AddrW-1:0] ptr_q;
  logic [AddrW-1:0] ptr_d;
  logic [AddrW-1:0] rd_addr;
  logic [WordW-1:0] word_old;
  logic [WordW-1:0] word_new;
  logic             wrap;

  assign wrap     = (CmpW'(ptr_q) + CmpW'(1)) >= CmpW'(width_i);
  assign ptr_d    = (wrap || restart_i) ? '0 : ptr_q + AddrW'(1);
  assign rd_addr  = step_i ? ptr_d : ptr_q;
  assign word_old = fwd_q ? fwd_word_q : rdata_q;
  assign word_new = (word_old << 1) | WordW'(pixel_i);
  assign col_o    = {word_old, pixel_i};

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      mem_q[ptr_q] <= word_new;
    end
    rdata_q    <= mem_q[rd_addr];
    fwd_word_q <= word_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= step_i && (ptr_d == ptr_q);
      if (step_i) begin
        ptr_q <= ptr_d;
      end
    end
  end

endmodule

FILE: rtl/core/bmwf_cell.sv
// One column of the filter window: holds one bit per window row and passes
// the column to its neighbor on every stream step. Reports a hit for its column.
// Depends on bmwf_pkg.
module bmwf_cell
  import bmwf_pkg::*;
#(
  parameter int unsigned KDIM = KmaxDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [KDIM-1:0] col_i,
  output logic [KDIM-1:0] col_o,
  input  logic            erode_i,
  input  logic            col_ok_i,
  input  logic [KDIM-1:0] row_ok_i,
  input  logic [KDIM-1:0] mask_i,
  output logic            hit_o
);

  logic [KDIM-1:0] bits_q;
  logic [KDIM-1:0] term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
    end else if (step_i) begin
      bits_q <= col_i;
    end
  end

  assign term  = erode_i ? ~bits_q : bits_q;
  assign hit_o = col_ok_i && (|(mask_i & row_ok_i & term));
  assign col_o = bits_q;

endmodule

FILE: rtl/core/bmwf_ctrl.sv
// Control of the filter: configuration registers, geometry, raster counters
// and the stream step that moves the window and emits results.
// Depends on bmwf_pkg and bmwf_stream_if.
module bmwf_ctrl
  import bmwf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef,
  parameter int unsigned KDIM       = KmaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmwf_stream_if.sink cfg_i,
  bmwf_stream_if.sink pix_i,
  input  logic        stall_i,
  output geom_t       geom_o,
  output step_t       step_o,
  output logic        pad_o
);

  localparam logic [12:0]   MaxW13 = 13'(MAX_WIDTH);
  localparam logic [12:0]   MaxH13 = 13'(MAX_HEIGHT);
  localparam logic [KW-1:0] KDimK  = KW'(KDIM);

  logic             mode_q;
  logic [DimW-1:0]  img_width_q;
  logic [DimW-1:0]  img_height_q;
  logic [KW-1:0]    krows_q;
  logic [KW-1:0]    kcols_q;
  logic [KW-1:0]    arow_q;
  logic [KW-1:0]    acol_q;
  logic [MaskW-1:0] kmask_q;

  logic [DimW-1:0]  in_row_q;
  logic [DimW-1:0]  in_col_q;
  logic [DimW-1:0]  out_row_q;
  logic [DimW-1:0]  out_col_q;
  logic [LagW-1:0]  lag_q;

  logic [DimW-1:0]  w;
  logic [DimW-1:0]  h;
  logic [KW-1:0]    kr;
  logic [KW-1:0]    kc;
  logic [KW-1:0]    ar;
  logic [KW-1:0]    ac;
  logic [KW-1:0]    dr;
  logic [KW-1:0]    dc;
  logic [LagW-1:0]  delay;
  logic [MaskW-1:0] emask;

  logic frame_in;
  logic pad;
  logic fire;
  logic step;
  logic emit;
  logic last;
  logic in_wrap;
  logic out_wrap;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      img_width_q  <= RstImgDim;
      img_height_q <= RstImgDim;
      krows_q      <= RstKDim;
      kcols_q      <= RstKDim;
      arow_q       <= RstAnchor;
      acol_q       <= RstAnchor;
      kmask_q      <= RstMask;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.payload.index))
        CFG_MODE:        mode_q       <= cfg_i.payload.data[0];
        CFG_IMG_WIDTH:   img_width_q  <= cfg_i.payload.data[DimW-1:0];
        CFG_IMG_HEIGHT:  img_height_q <= cfg_i.payload.data[DimW-1:0];
        CFG_KERNEL_ROWS: krows_q      <= cfg_i.payload.data[KW-1:0];
        CFG_KERNEL_COLS: kcols_q      <= cfg_i.payload.data[KW-1:0];
        CFG_ANCHOR_ROW:  arow_q       <= cfg_i.payload.data[KW-1:0];
        CFG_ANCHOR_COL:  acol_q       <= cfg_i.payload.data[KW-1:0];
        CFG_KERNEL_MASK: kmask_q      <= cfg_i.payload.data[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w = (img_width_q == '0) ? DimW'(1) :
        ((13'(img_width_q) > MaxW13) ? DimW'(MAX_WIDTH) : img_width_q);
    h = (img_height_q == '0) ? DimW'(1) :
        ((13'(img_height_q) > MaxH13) ? DimW'(MAX_HEIGHT) : img_height_q);
    kr = (krows_q == '0) ? KW'(1) : ((krows_q > KDimK) ? KDimK : krows_q);
    kc = (kcols_q == '0) ? KW'(1) : ((kcols_q > KDimK) ? KDimK : kcols_q);
    ar = (arow_q > kr - KW'(1)) ? kr - KW'(1) : arow_q;
    ac = (acol_q > kc - KW'(1)) ? kc - KW'(1) : acol_q;
    dr = mode_q ? kr - KW'(1) - ar : ar;
    dc = mode_q ? kc - KW'(1) - ac : ac;
    delay = LagW'(dr) * LagW'(w) + LagW'(dc);
  end

  always_comb begin
    logic [KW-1:0] ri;
    logic [KW-1:0] cj;
    logic [4:0]    idx;
    emask = '0;
    for (int a = 0; a < KDIM; a++) begin
      for (int b = 0; b < KDIM; b++) begin
        ri  = mode_q ? kr - KW'(1) - KW'(a) : KW'(a);
        cj  = mode_q ? kc - KW'(1) - KW'(b) : KW'(b);
        idx = 5'(ri) * 5'(MaskStride) + 5'(cj);
        emask[a*MaskStride+b] = (KW'(a) < kr) && (KW'(b) < kc) && kmask_q[idx];
      end
    end
  end

  assign frame_in    = in_row_q >= h;
  assign pad         = frame_in && (lag_q < delay);
  assign pix_i.ready = !stall_i && !pad;
  assign fire        = pix_i.valid && pix_i.ready;
  assign step        = (fire && (frame_in || !pix_i.payload.req_type)) || (pad && !stall_i);
  assign emit        = step && (lag_q >= delay);
  assign last        = (out_row_q == h - DimW'(1)) && (out_col_q == w - DimW'(1));
  assign in_wrap     = ((DimW+1)'(in_col_q) + (DimW+1)'(1)) >= (DimW+1)'(w);
  assign out_wrap    = ((DimW+1)'(out_col_q) + (DimW+1)'(1)) >= (DimW+1)'(w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      lag_q     <= '0;
    end else if (step) begin
      if (emit && last) begin
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
        lag_q     <= '0;
      end else begin
        if (!frame_in) begin
          if (in_wrap) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + DimW'(1);
          end else begin
            in_col_q <= in_col_q + DimW'(1);
          end
        end
        if (emit) begin
          if (out_wrap) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + DimW'(1);
          end else begin
            out_col_q <= out_col_q + DimW'(1);
          end
        end else begin
          lag_q <= lag_q + LagW'(1);
        end
      end
    end
  end

  assign geom_o = '{erode: mode_q, width: w, height: h, dr: dr, dc: dc, mask: emask};

  assign step_o = '{step: step, emit: emit, last: last, pixel: !frame_in && pix_i.payload.pixel_in,
                    row: out_row_q, col: out_col_q};

  assign pad_o = pad;

endmodule

FILE: tb/sv/bmwf_morph_checker.sv
// Result checker for the binary morphology window filter.
// Shadows the registers, predicts dilation/erosion output per input transaction
// and compares every output transaction in order. Depends on bmwf_pkg.
module bmwf_morph_checker
  import bmwf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  cfg_wr_t     cfg_payload_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_payload_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_payload_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KDim      = (KmaxDef < MaskStride) ? KmaxDef : MaskStride;
  localparam int HistDepth = (KmaxDef - 1) * MaxWidthDef + KmaxDef;

  typedef struct {
    int w;
    int h;
    int kr;
    int kc;
    int ar;
    int ac;
    int lag;
  } frame_shape_t;

  logic             erode_q;
  logic [DimW-1:0]  width_q;
  logic [DimW-1:0]  height_q;
  logic [KW-1:0]    krows_q;
  logic [KW-1:0]    kcols_q;
  logic [KW-1:0]    arow_q;
  logic [KW-1:0]    acol_q;
  logic [MaskW-1:0] mask_q;

  bit        pixel_history [HistDepth];
  int        in_row;
  int        in_col;
  int        out_row;
  int        out_col;
  out_item_t expected_pixels [$];

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic frame_shape_t current_shape();
    frame_shape_t s;
    int dr;
    int dc;
    s.w  = clamp(int'(width_q), 1, MaxWidthDef);
    s.h  = clamp(int'(height_q), 1, MaxHeightDef);
    s.kr = clamp(int'(krows_q), 1, KDim);
    s.kc = clamp(int'(kcols_q), 1, KDim);
    s.ar = clamp(int'(arow_q), 0, s.kr - 1);
    s.ac = clamp(int'(acol_q), 0, s.kc - 1);
    dr = erode_q ? s.kr - 1 - s.ar : s.ar;
    dc = erode_q ? s.kc - 1 - s.ac : s.ac;
    s.lag = dr * s.w + dc;
    return s;
  endfunction

  function automatic logic filter_pixel(frame_shape_t s, int r, int c);
    int sr;
    int sc;
    bit px;
    for (int i = 0; i < s.kr; i++) begin
      for (int j = 0; j < s.kc; j++) begin
        if (!mask_q[i * MaskStride + j]) continue;
        sr = erode_q ? r - s.ar + i : r + s.ar - i;
        sc = erode_q ? c - s.ac + j : c + s.ac - j;
        if (sr < 0 || sr >= s.h || sc < 0 || sc >= s.w) continue;
        px = pixel_history[(sr * s.w + sc) % HistDepth];
        if (erode_q && !px) return 1'b0;
        if (!erode_q && px) return 1'b1;
      end
    end
    return erode_q;
  endfunction

  function automatic bit emit_output(frame_shape_t s, output out_item_t o);
    if (out_row >= s.h) return 1'b0;
    if (out_col >= s.w) out_col = s.w - 1;
    o.pixel_out     = filter_pixel(s, out_row, out_col);
    o.last_of_frame = (out_row == s.h - 1) && (out_col == s.w - 1);
    if (o.last_of_frame) begin
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
    end else if (out_col + 1 >= s.w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    return 1'b1;
  endfunction

  function automatic void accept_item(in_item_t it);
    frame_shape_t s;
    out_item_t    o;
    int           lin;
    s = current_shape();
    if (in_row >= s.h) begin
      if (emit_output(s, o)) expected_pixels.push_back(o);
    end else if (!it.req_type) begin
      if (in_col >= s.w) in_col = s.w - 1;
      lin = in_row * s.w + in_col;
      pixel_history[lin % HistDepth] = it.pixel_in;
      if (in_col + 1 >= s.w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col++;
      end
      if (lin >= s.lag && emit_output(s, o)) expected_pixels.push_back(o);
    end
  endfunction

  function automatic void write_shadow(cfg_wr_t wr);
    case (cfg_reg_e'(wr.index))
      CFG_MODE:        erode_q  = wr.data[0];
      CFG_IMG_WIDTH:   width_q  = wr.data[DimW-1:0];
      CFG_IMG_HEIGHT:  height_q = wr.data[DimW-1:0];
      CFG_KERNEL_ROWS: krows_q  = wr.data[KW-1:0];
      CFG_KERNEL_COLS: kcols_q  = wr.data[KW-1:0];
      CFG_ANCHOR_ROW:  arow_q   = wr.data[KW-1:0];
      CFG_ANCHOR_COL:  acol_q   = wr.data[KW-1:0];
      CFG_KERNEL_MASK: mask_q   = wr.data[MaskW-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (expected_pixels.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: unexpected result pixel_out=%0d last_of_frame=%0d",
                 $realtime, got.pixel_out, got.last_of_frame);
      return;
    end
    want = expected_pixels.pop_front();
    if (got.pixel_out !== want.pixel_out || got.last_of_frame !== want.last_of_frame) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: mismatch expected pixel_out=%0d last_of_frame=%0d, got %0d %0d",
                 $realtime, want.pixel_out, want.last_of_frame,
                 got.pixel_out, got.last_of_frame);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erode_q  = 1'b0;
      width_q  = RstImgDim;
      height_q = RstImgDim;
      krows_q  = RstKDim;
      kcols_q  = RstKDim;
      arow_q   = RstAnchor;
      acol_q   = RstAnchor;
      mask_q   = RstMask;
      in_row   = 0;
      in_col   = 0;
      out_row  = 0;
      out_col  = 0;
      expected_pixels.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_payload_i);
      if (cfg_valid_i && cfg_ready_i) write_shadow(cfg_payload_i);
      if (in_valid_i && in_ready_i) accept_item(in_payload_i);
      pending_o = expected_pixels.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Top of the binary morphology window filter regression.
// Drives frames, register settings and backpressure; the checker module
// predicts and compares. Depends on bmwf_pkg, bmwf_stream_if and the block.
module tb
  import bmwf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LongHold = 400;
  localparam int ItemGoal = 1650;

  typedef struct {
    logic             erode;
    int               w;
    int               h;
    int               kr;
    int               kc;
    int               ar;
    int               ac;
    logic [MaskW-1:0] mask;
  } morph_setup_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int          holds_asked = 0;
  bit          hold_at_start = 1'b0;
  bit          calm = 1'b0;
  int          sent_items = 0;

  bmwf_stream_if #(.payload_t(cfg_wr_t))   cfg_if ();
  bmwf_stream_if #(.payload_t(in_item_t))  pix_in_if ();
  bmwf_stream_if #(.payload_t(out_item_t)) pix_out_if ();

  always #1ns clk_i = ~clk_i;

  binary_morphology_window_filter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_in_if),
    .pix_o  (pix_out_if)
  );

  bmwf_morph_checker morph_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_payload_i (cfg_if.payload),
    .in_valid_i    (pix_in_if.valid),
    .in_ready_i    (pix_in_if.ready),
    .in_payload_i  (pix_in_if.payload),
    .out_valid_i   (pix_out_if.valid),
    .out_ready_i   (pix_out_if.ready),
    .out_payload_i (pix_out_if.payload),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin : result_sink
    int idle_left;
    int hold_left;
    int holds_served;
    idle_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    pix_out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left    = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out_if.ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        pix_out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(1, 3) - 1;
        pix_out_if.ready <= 1'b0;
      end else begin
        pix_out_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(logic flush, logic px);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pix_in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    pix_in_if.valid   <= 1'b1;
    pix_in_if.payload <= in_item_t'{req_type: flush, pixel_in: px};
    @(posedge clk_i);
    while (!pix_in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle_input();
    pix_in_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_results();
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic put_reg(cfg_reg_e idx, int unsigned value);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= cfg_wr_t'{index: idx, data: CfgDataW'(value)};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // registers change only between frames, once the block has gone quiet
  task automatic load_setup(morph_setup_t s);
    settle_input();
    wait_results();
    repeat (8) @(negedge clk_i);
    put_reg(CFG_MODE, s.erode);
    put_reg(CFG_IMG_WIDTH, s.w);
    put_reg(CFG_IMG_HEIGHT, s.h);
    put_reg(CFG_KERNEL_ROWS, s.kr);
    put_reg(CFG_KERNEL_COLS, s.kc);
    put_reg(CFG_ANCHOR_ROW, s.ar);
    put_reg(CFG_ANCHOR_COL, s.ac);
    put_reg(CFG_KERNEL_MASK, s.mask);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic int drain_items(morph_setup_t s);
    int ar;
    int ac;
    int lag;
    ar  = (s.ar < s.kr) ? s.ar : s.kr - 1;
    ac  = (s.ac < s.kc) ? s.ac : s.kc - 1;
    lag = (s.erode ? s.kr - 1 - ar : ar) * s.w + (s.erode ? s.kc - 1 - ac : ac);
    return (lag < s.w * s.h) ? lag : s.w * s.h;
  endfunction

  task automatic run_pattern(morph_setup_t s, logic [31:0] bits);
    int n;
    int d;
    n = s.w * s.h;
    d = drain_items(s);
    load_setup(s);
    for (int k = 0; k < n; k++) begin
      if (k == 1) push_item(1'b1, 1'b1);
      push_item(1'b0, bits[k]);
    end
    for (int k = 0; k < d; k++) push_item(logic'(k % 2), logic'(k % 3 == 0));
    push_item(1'b1, 1'b0);
  endtask

  task automatic run_frame(morph_setup_t s, int one_pct, bit pause_mid);
    int n;
    int d;
    n = s.w * s.h;
    d = drain_items(s);
    load_setup(s);
    if (hold_at_start) begin
      hold_at_start = 1'b0;
      holds_asked++;
    end
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) push_item(1'b1, 1'($urandom));
      if (pause_mid && k == n / 2) begin
        settle_input();
        wait_results();
      end
      push_item(1'b0, logic'($urandom_range(0, 99) < one_pct));
    end
    for (int k = 0; k < d; k++) push_item(1'($urandom), 1'($urandom));
    if ($urandom_range(0, 3) == 0) push_item(1'b1, 1'($urandom));
    sent_items += n + d;
  endtask

  function automatic morph_setup_t random_setup();
    morph_setup_t s;
    s.erode = 1'($urandom);
    s.w  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
    s.h  = $urandom_range(1, 8);
    s.kr = $urandom_range(1, 5);
    s.kc = $urandom_range(1, 5);
    s.ar = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(0, s.kr - 1);
    s.ac = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(0, s.kc - 1);
    case ($urandom_range(0, 7))
      0:       s.mask = '1;
      1:       s.mask = '0;
      2, 3:    s.mask = MaskW'($urandom) & MaskW'($urandom);
      default: s.mask = MaskW'($urandom);
    endcase
    return s;
  endfunction

  initial begin : stimulus
    morph_setup_t s;
    int           one_pct;
    bit           paused;
    paused = 1'b0;
    pix_in_if.valid   = 1'b0;
    pix_in_if.payload = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.payload    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // flush with nothing in flight
    push_item(1'b1, 1'b0);

    // dilation whose reach exceeds the frame, then erosion with an empty mask
    run_pattern('{1'b0, 2, 2, 5, 5, 4, 4, '1}, 32'b0001);
    run_pattern('{1'b1, 3, 2, 2, 2, 0, 0, '0}, 32'b011010);

    // widest row, then a tall column that rides through a long output stall
    run_frame('{1'b1, 1024, 1, 1, 5, 0, 4, 25'h000001F}, 90, 1'b0);
    hold_at_start = 1'b1;
    run_frame('{1'b0, 1, 256, 5, 1, 4, 0, '1}, 3, 1'b0);

    while (sent_items < ItemGoal) begin
      if (sent_items > ItemGoal - 300) calm = 1'b1;
      s = random_setup();
      one_pct = s.erode ? $urandom_range(60, 97) : $urandom_range(2, 35);
      if ($urandom_range(0, 4) == 0) one_pct = 50;
      run_frame(s, one_pct, !paused && s.w * s.h > 8);
      if (s.w * s.h > 8) paused = 1'b1;
    end

    settle_input();
    wait_results();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("binary_morphology_window_filter regression: pass");
    end else begin
      $display("binary_morphology_window_filter regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("binary_morphology_window_filter regression: fail");
    $finish;
  end

endmodule
